/* src/bresenham_line_pixel_generator_assert.svh */
// Assertion macros shared by the checker of the line pixel generator.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line pixel generator check failed");

// Next-cycle implication, checked outside reset.
`define BLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line pixel generator check failed");

`endif

/* src/blpg_pkg.sv */
// Package of the line pixel generator: request codes, widths and shared types.
package blpg_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int COLOR_BITS     = 16;

	typedef enum logic {
		REQ_START   = 1'b0,
		REQ_ADVANCE = 1'b1
	} req_t;

	// Direction flags of the active line.
	typedef struct packed {
		logic x_is_major;
		logic x_dir_neg;
		logic y_dir_neg;
	} line_dir_t;

endpackage

/* src/bresenham_line_pixel_generator.sv */
// Top level of the Bresenham line pixel generator.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid/in_ready    req_type, x_start, y_start, x_end, y_end,
//                                            line_color
//   out      source     out_valid/out_ready  pixel_x, pixel_y, pixel_color, last_pixel
//
// Every input transaction is handled in the cycle it is accepted: one transaction per
// clock unless the output stalls, limited by the update of the line state registers.
// A pixel appears on the output in the cycle after the advance transaction that made it.
// The output register is the only buffer; input is taken while it is empty or drained.
// A stalled output holds its pixel and blocks input until the pixel is taken.
// Reset (arst_n low) drops any active line and empties the output register.
module bresenham_line_pixel_generator #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [COORD_BITS-1:0]           x_start,
	input  logic [COORD_BITS-1:0]           y_start,
	input  logic [COORD_BITS-1:0]           x_end,
	input  logic [COORD_BITS-1:0]           y_end,
	input  logic [blpg_pkg::COLOR_BITS-1:0] line_color,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [COORD_BITS-1:0]           pixel_x,
	output logic [COORD_BITS-1:0]           pixel_y,
	output logic [blpg_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                            last_pixel
);
	import blpg_pkg::*;

	localparam int EW = COORD_BITS + 3;

	// Line state. The active flag qualifies all other state registers.
	logic                   active_q;
	logic [COORD_BITS-1:0]  cur_x_q;
	logic [COORD_BITS-1:0]  cur_y_q;
	logic [COORD_BITS-1:0]  major_q;
	logic [COORD_BITS-1:0]  minor_q;
	logic signed [EW-1:0]   err_q;
	logic [COORD_BITS-1:0]  steps_q;
	line_dir_t              dir_q;
	logic [COLOR_BITS-1:0]  color_q;

	// Output register.
	logic                   out_valid_q;
	logic [COORD_BITS-1:0]  pixel_x_q;
	logic [COORD_BITS-1:0]  pixel_y_q;
	logic [COLOR_BITS-1:0]  pixel_color_q;
	logic                   last_pixel_q;

	// Setup results for a start transaction.
	line_dir_t              set_dir;
	logic [COORD_BITS-1:0]  set_major;
	logic [COORD_BITS-1:0]  set_minor;
	logic signed [EW-1:0]   set_err;

	// Step results for an advance transaction.
	logic [COORD_BITS-1:0]  nxt_x;
	logic [COORD_BITS-1:0]  nxt_y;
	logic signed [EW-1:0]   nxt_err;
	logic [COORD_BITS-1:0]  nxt_steps;
	logic                   is_last;

	logic                   accept;
	logic                   is_start;
	logic                   emit;

	blpg_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.dir      (set_dir),
		.major    (set_major),
		.minor    (set_minor),
		.err_init (set_err)
	);

	blpg_step #(.COORD_BITS(COORD_BITS)) u_step (
		.cur_x     (cur_x_q),
		.cur_y     (cur_y_q),
		.major     (major_q),
		.minor     (minor_q),
		.err       (err_q),
		.steps     (steps_q),
		.dir       (dir_q),
		.nxt_x     (nxt_x),
		.nxt_y     (nxt_y),
		.nxt_err   (nxt_err),
		.nxt_steps (nxt_steps),
		.is_last   (is_last)
	);

	// Input is taken whenever the output register is empty or being emptied.
	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;
	assign is_start = req_type == REQ_START;
	// An advance with no active line is accepted and dropped.
	assign emit     = accept & ~is_start & active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_start) begin
				active_q <= 1'b1;
			end else if (emit && is_last) begin
				active_q <= 1'b0;
			end
			if (in_ready) begin
				out_valid_q <= emit;
			end
		end
	end

	// Line state payload; only meaningful while the line is active.
	always_ff @(posedge clk) begin
		if (accept && is_start) begin
			cur_x_q <= x_start;
			cur_y_q <= y_start;
			major_q <= set_major;
			minor_q <= set_minor;
			err_q   <= set_err;
			steps_q <= set_major;
			dir_q   <= set_dir;
			color_q <= line_color;
		end else if (emit && !is_last) begin
			cur_x_q <= nxt_x;
			cur_y_q <= nxt_y;
			err_q   <= nxt_err;
			steps_q <= nxt_steps;
		end
	end

	// The pixel shown is the current position, before the step.
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q     <= cur_x_q;
			pixel_y_q     <= cur_y_q;
			pixel_color_q <= color_q;
			last_pixel_q  <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last_pixel  = last_pixel_q;

endmodule

/* src/blpg_setup.sv */
// Line setup: deltas, step directions, major axis and initial error term.
module blpg_setup #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0]         x_start,
	input  logic [COORD_BITS-1:0]         y_start,
	input  logic [COORD_BITS-1:0]         x_end,
	input  logic [COORD_BITS-1:0]         y_end,
	output blpg_pkg::line_dir_t           dir,
	output logic [COORD_BITS-1:0]         major,
	output logic [COORD_BITS-1:0]         minor,
	output logic signed [COORD_BITS+2:0]  err_init
);
	import blpg_pkg::*;

	localparam int EW = COORD_BITS + 3;

	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic                  x_neg;
	logic                  y_neg;
	logic                  x_maj;

	always_comb begin
		x_neg = x_end < x_start;
		y_neg = y_end < y_start;
		adx   = x_neg ? (x_start - x_end) : (x_end - x_start);
		ady   = y_neg ? (y_start - y_end) : (y_end - y_start);
		x_maj = adx >= ady;
		major = x_maj ? adx : ady;
		minor = x_maj ? ady : adx;
		dir.x_is_major = x_maj;
		dir.x_dir_neg  = x_neg;
		dir.y_dir_neg  = y_neg;
		// Twice the minor delta less the major delta.
		err_init = $signed(EW'({minor, 1'b0})) - $signed(EW'(major));
	end

endmodule

/* src/blpg_step.sv */
// One Bresenham step: next coordinates, error term and remaining count.
module blpg_step #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0]         cur_x,
	input  logic [COORD_BITS-1:0]         cur_y,
	input  logic [COORD_BITS-1:0]         major,
	input  logic [COORD_BITS-1:0]         minor,
	input  logic signed [COORD_BITS+2:0]  err,
	input  logic [COORD_BITS-1:0]         steps,
	input  blpg_pkg::line_dir_t           dir,
	output logic [COORD_BITS-1:0]         nxt_x,
	output logic [COORD_BITS-1:0]         nxt_y,
	output logic signed [COORD_BITS+2:0]  nxt_err,
	output logic [COORD_BITS-1:0]         nxt_steps,
	output logic                          is_last
);
	import blpg_pkg::*;

	localparam int EW = COORD_BITS + 3;

	logic                  err_nonneg;
	logic                  step_x;
	logic                  step_y;
	logic signed [EW-1:0]  major2;
	logic signed [EW-1:0]  minor2;

	always_comb begin
		err_nonneg = ~err[EW-1];
		is_last    = steps == '0;
		// The major axis always moves; the minor one moves when the error is not negative.
		step_x     = dir.x_is_major | err_nonneg;
		step_y     = ~dir.x_is_major | err_nonneg;
		major2     = $signed(EW'({major, 1'b0}));
		minor2     = $signed(EW'({minor, 1'b0}));

		nxt_x = cur_x;
		if (step_x) begin
			nxt_x = dir.x_dir_neg ? (cur_x - COORD_BITS'(1)) : (cur_x + COORD_BITS'(1));
		end
		nxt_y = cur_y;
		if (step_y) begin
			nxt_y = dir.y_dir_neg ? (cur_y - COORD_BITS'(1)) : (cur_y + COORD_BITS'(1));
		end
		nxt_err   = err + minor2 - (err_nonneg ? major2 : EW'(0));
		nxt_steps = steps - COORD_BITS'(1);
	end

endmodule

/* src/blpg_checker.sv */
// Port-level checker of the line pixel generator and its bind statement.
`include "bresenham_line_pixel_generator_assert.svh"

module blpg_checker #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            req_type,
	input logic [COORD_BITS-1:0]           x_start,
	input logic [COORD_BITS-1:0]           y_start,
	input logic [COORD_BITS-1:0]           x_end,
	input logic [COORD_BITS-1:0]           y_end,
	input logic [blpg_pkg::COLOR_BITS-1:0] line_color,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [COORD_BITS-1:0]           pixel_x,
	input logic [COORD_BITS-1:0]           pixel_y,
	input logic [blpg_pkg::COLOR_BITS-1:0] pixel_color,
	input logic                            last_pixel
);
	import blpg_pkg::*;

	logic in_acc;
	logic start_acc;
	logic adv_acc;
	logic zero_len;

	assign in_acc    = in_valid & in_ready;
	assign start_acc = in_acc & (req_type == REQ_START);
	assign adv_acc   = in_acc & (req_type == REQ_ADVANCE);
	assign zero_len  = (x_start == x_end) & (y_start == y_end);

	// A stalled pixel holds until it is taken.
	`BLPG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(last_pixel))

	// An empty output register never blocks the input side.
	`BLPG_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// A start transaction never produces a pixel.
	`BLPG_ASSERT_NEXT(a_start_silent, clk, arst_n, start_acc && !out_valid, !out_valid)

	// A zero-length line gives its single endpoint, flagged last, on the next advance.
	`BLPG_ASSERT_NEXT(a_zero_len, clk, arst_n, (start_acc && zero_len) ##1 adv_acc, out_valid && last_pixel && pixel_x == $past(x_start, 2) && pixel_y == $past(y_start, 2) && pixel_color == $past(line_color, 2))

endmodule

bind bresenham_line_pixel_generator blpg_checker #(.COORD_BITS(COORD_BITS)) u_blpg_checker (.*);
